// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared widths, operation codes and the records that travel between the
// scheduler control and the row of task cells.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int NUM_TASKS = 8;
	localparam int IDX_W     = $clog2(NUM_TASKS);
	localparam int TASK_W    = 3;
	localparam int PRIO_W    = 8;
	localparam int WORD_W    = 32;
	localparam int OP_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 2'd0,
		OP_DELAY  = 2'd1,
		OP_SWITCH = 2'd2
	} op_t;

	// Best-so-far record handed from cell to cell during a scan
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [PRIO_W-1:0] prio;
		logic [WORD_W-1:0] sp;
	} cand_t;

	// Write command broadcast to every cell
	typedef struct packed {
		logic              create;
		logic              delay;
		logic              save;
		logic [PRIO_W-1:0] prio;
		logic [WORD_W-1:0] sp;
		logic [WORD_W-1:0] wake;
	} cmd_t;

endpackage

// ----- rtl/pts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler channels
// Request channel (operation items) and response channel (switch results),
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface pts_req_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TASK_W-1:0] task_index;
	logic [PRIO_W-1:0] task_priority_in;
	logic [WORD_W-1:0] delay_ticks;
	logic [WORD_W-1:0] now_ticks;
	logic [WORD_W-1:0] stack_ptr;

	modport source (
		output valid, op, task_index, task_priority_in, delay_ticks, now_ticks, stack_ptr,
		input  ready
	);
	modport sink (
		input  valid, op, task_index, task_priority_in, delay_ticks, now_ticks, stack_ptr,
		output ready
	);
endinterface

interface pts_rsp_if import pts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TASK_W-1:0] next_task;
	logic [WORD_W-1:0] next_stack_ptr;
	logic              none_ready;

	modport source (
		output valid, next_task, next_stack_ptr, none_ready,
		input  ready
	);
	modport sink (
		input  valid, next_task, next_stack_ptr, none_ready,
		output ready
	);
endinterface

// ----- rtl/pts_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler cell
// Holds one task slot and, when the scan token passes, wakes the slot if due
// and merges it into the best-so-far record handed to the next cell.
// ----------------------------------------------------------------------------
module pts_cell import pts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  slot_id,
	input  cmd_t              cmd,
	input  logic              sel_create,
	input  logic              is_cur,
	input  logic [WORD_W-1:0] now,
	input  logic              tok_in,
	input  cand_t             cand_in,
	output logic              tok_out,
	output cand_t             cand_out
);

	typedef enum logic [1:0] {
		TS_UNUSED  = 2'd0,
		TS_READY   = 2'd1,
		TS_BLOCKED = 2'd2
	} task_state_t;

	task_state_t       state_q;
	logic [PRIO_W-1:0] prio_q;
	logic [WORD_W-1:0] wake_q;
	logic [WORD_W-1:0] sp_q;
	logic              tok_q;
	cand_t             cand_q;

	logic woken;
	logic ready;
	logic take;

	assign woken = (state_q == TS_BLOCKED) && (wake_q <= now);
	assign ready = (state_q == TS_READY) || woken;
	assign take  = ready && (!cand_in.found || (prio_q > cand_in.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_UNUSED;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (cmd.create && sel_create) begin
				state_q <= TS_READY;
			end else if (cmd.delay && is_cur) begin
				state_q <= TS_BLOCKED;
			end else if (tok_in && woken) begin
				state_q <= TS_READY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create && sel_create) begin
			prio_q <= cmd.prio;
		end
		if (cmd.delay && is_cur) begin
			wake_q <= cmd.wake;
		end
		if ((cmd.create && sel_create) || (cmd.save && is_cur)) begin
			sp_q <= cmd.sp;
		end
		// hold the record once the token has moved on
		if (tok_in) begin
			if (take) begin
				cand_q <= '{found: 1'b1, idx: slot_id, prio: prio_q, sp: sp_q};
			end else begin
				cand_q <= cand_in;
			end
		end
	end

	assign tok_out  = tok_q;
	assign cand_out = cand_q;

endmodule

// ----- rtl/priority_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler
// Task table in a ring of cells with a round-robin priority scan on switch.
// ----------------------------------------------------------------------------
// Each task slot lives in its own cell. Create and delay requests are taken
// while the request side is idle and written straight into the addressed
// cell (delay acts on the running task, waking at now_ticks + delay_ticks,
// wrapping modulo 2^32). A switch request saves the outgoing stack pointer
// and launches a scan token into the cell after the running task; the token
// and a best-so-far record step one cell per cycle round the ring, so a
// switch keeps the request side busy until the token has gone round the
// whole ring back to the running task's cell. The result then sits in an
// output register; create and delay requests are taken while it waits to be
// collected. A further switch is taken as well, but once its scan has
// finished its answer waits in the ring, and the request side stays busy,
// until the previous result has gone.
// If no task is ready the running task is kept and none_ready is raised.
// ----------------------------------------------------------------------------
module priority_task_scheduler import pts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pts_req_if.sink   req,
	pts_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_HOLD = 2'd2
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cur_q;
	logic              start_q;
	logic [WORD_W-1:0] now_q;
	logic [WORD_W-1:0] sp_q;
	logic              rsp_valid_q;
	logic [TASK_W-1:0] rsp_task_q;
	logic [WORD_W-1:0] rsp_sp_q;
	logic              rsp_none_q;

	logic              accept;
	logic              is_create;
	logic              is_delay;
	logic              is_switch;
	cmd_t              cmd;
	logic [IDX_W-1:0]  nxt;
	cand_t             init_cand;
	logic              fin;
	logic              load;
	cand_t             res;

	logic [NUM_TASKS-1:0] tok;
	cand_t                cand [NUM_TASKS];

	// decode the request
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		is_create = 1'b0;
		is_delay  = 1'b0;
		is_switch = 1'b0;
		unique case (op_t'(req.op))
			OP_CREATE: is_create = accept;
			OP_DELAY:  is_delay  = accept;
			OP_SWITCH: is_switch = accept;
			default: begin
				// unused code: drop the request
			end
		endcase
	end

	assign cmd = '{
		create: is_create,
		delay:  is_delay,
		save:   is_switch,
		prio:   req.task_priority_in,
		sp:     req.stack_ptr,
		wake:   req.now_ticks + req.delay_ticks
	};

	// scan starts in the slot after the running task
	assign nxt       = (cur_q == IDX_W'(NUM_TASKS - 1)) ? '0 : cur_q + IDX_W'(1);
	assign init_cand = '{found: 1'b0, idx: cur_q, prio: '0, sp: sp_q};

	// ring of task cells
	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		localparam int PREV = (i + NUM_TASKS - 1) % NUM_TASKS;

		logic  inject;
		logic  tok_in;
		cand_t cand_in;
		logic  sel_create;

		assign inject     = start_q && (nxt == IDX_W'(i));
		// stop the token once the running task's cell has been visited
		assign tok_in     = inject || (tok[PREV] && (cur_q != IDX_W'(PREV)));
		assign cand_in    = inject ? init_cand : cand[PREV];
		assign sel_create = ({{(WORD_W - TASK_W){1'b0}}, req.task_index} == WORD_W'(i));

		pts_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.slot_id    (IDX_W'(i)),
			.cmd        (cmd),
			.sel_create (sel_create),
			.is_cur     (cur_q == IDX_W'(i)),
			.now        (now_q),
			.tok_in     (tok_in),
			.cand_in    (cand_in),
			.tok_out    (tok[i]),
			.cand_out   (cand[i])
		);
	end

	// the record leaving the running task's cell is the answer
	assign res  = cand[cur_q];
	assign fin  = ((state_q == ST_SCAN) && tok[cur_q]) || (state_q == ST_HOLD);
	assign load = fin && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= is_switch;
			unique case (state_q)
				ST_IDLE: begin
					if (is_switch) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end else if (fin) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				rsp_valid_q <= 1'b1;
				cur_q       <= res.idx;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (is_switch) begin
			now_q <= req.now_ticks;
			sp_q  <= req.stack_ptr;
		end
		if (load) begin
			rsp_task_q <= TASK_W'(res.idx);
			rsp_sp_q   <= res.sp;
			rsp_none_q <= !res.found;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.next_task      = rsp_task_q;
	assign rsp.next_stack_ptr = rsp_sp_q;
	assign rsp.none_ready     = rsp_none_q;

	// at most one scan token is ever in the ring
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one scan token in the ring");

	// tokens only circulate while a scan is running
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> (tok == '0))
		else $error("scan token outside a scan");

	// an accepted switch always starts a scan
	a_switch_scans: assert property (@(posedge clk) disable iff (!arst_n)
		is_switch |=> (state_q == ST_SCAN) && start_q)
		else $error("switch request did not start a scan");

	// the chosen task becomes the running task
	a_cur_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (TASK_W'(cur_q) == rsp.next_task) && rsp.valid)
		else $error("running task does not match the result");

endmodule

// ----- sim/tb_priority_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives create, delay and switch requests through the request channel and
// checks every switch result against a cycle-free model of the task table.
// The model is updated as each request is accepted. A short directed list
// comes first, then random phases with bursty idling on both channels, a long
// receiver hold-off that backs the scheduler up, and a final stretch with
// no idling at all.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;
	import pts_pkg::*;

	// Op value left undefined by the scheduler: it must be taken and ignored
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

	typedef enum logic [1:0] {
		SLOT_UNUSED,
		SLOT_READY,
		SLOT_BLOCKED
	} slot_state_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TASK_W-1:0] task_index;
		logic [PRIO_W-1:0] task_priority_in;
		logic [WORD_W-1:0] delay_ticks;
		logic [WORD_W-1:0] now_ticks;
		logic [WORD_W-1:0] stack_ptr;
	} task_request_t;

	typedef struct packed {
		logic [TASK_W-1:0] next_task;
		logic [WORD_W-1:0] next_stack_ptr;
		logic              none_ready;
	} switch_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	pts_req_if req ();
	pts_rsp_if rsp ();

	priority_task_scheduler DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Model of the task table, advanced once per accepted request
	// ------------------------------------------------------------------------
	slot_state_t       slot_state [NUM_TASKS] = '{default: SLOT_UNUSED};
	logic [PRIO_W-1:0] slot_prio  [NUM_TASKS];
	logic [WORD_W-1:0] slot_wake  [NUM_TASKS];
	logic [WORD_W-1:0] slot_sp    [NUM_TASKS];
	int unsigned       running_slot = 0;

	task_request_t   task_requests [$];   // waiting to be offered
	switch_outcome_t switch_outcomes [$]; // predicted, not yet collected

	task_request_t   on_bus;
	switch_outcome_t oldest;

	int unsigned src_gap       = 0;
	int unsigned sink_gap      = 0;
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned hold_left     = 0;
	int unsigned mismatches    = 0;
	logic [WORD_W-1:0] tick    = '0;

	// Apply one accepted request to the model; a switch yields a prediction
	function automatic void schedule_request(task_request_t r);
		int unsigned cur;
		int unsigned best;
		int unsigned n;
		int unsigned i;
		logic found;
		switch_outcome_t res;
		cur = running_slot;
		case (r.op)
			OP_CREATE: begin
				slot_prio[r.task_index]  = r.task_priority_in;
				slot_sp[r.task_index]    = r.stack_ptr;
				slot_state[r.task_index] = SLOT_READY;
			end
			OP_DELAY: begin
				// 32-bit sum, wraps silently
				slot_wake[cur]  = r.now_ticks + r.delay_ticks;
				slot_state[cur] = SLOT_BLOCKED;
			end
			OP_SWITCH: begin
				slot_sp[cur] = r.stack_ptr;
				found = 1'b0;
				best = cur;
				// scan from the slot after the running one, round to itself;
				// strict compare keeps the first of equal priorities
				for (i = 1; i <= NUM_TASKS; i++) begin
					n = (cur + i) % NUM_TASKS;
					if (slot_state[n] == SLOT_BLOCKED && slot_wake[n] <= r.now_ticks)
						slot_state[n] = SLOT_READY;
					if (slot_state[n] == SLOT_READY && (!found || slot_prio[n] > slot_prio[best])) begin
						best = n;
						found = 1'b1;
					end
				end
				running_slot = best;
				res.next_task      = TASK_W'(best);
				res.next_stack_ptr = slot_sp[best];
				res.none_ready     = !found;
				switch_outcomes.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: offer queued requests, idle in random bursts
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (req.valid && req.ready)
				schedule_request(on_bus);
			if (!req.valid || req.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					req.valid <= 1'b0;
				end else if (task_requests.size() != 0 && src_idle_pct != 0 &&
						$urandom_range(0, 99) < src_idle_pct) begin
					// this cycle counts as the first of the burst
					src_gap = $urandom_range(0, 17);
					req.valid <= 1'b0;
				end else if (task_requests.size() != 0) begin
					on_bus = task_requests.pop_front();
					req.valid            <= 1'b1;
					req.op               <= on_bus.op;
					req.task_index       <= on_bus.task_index;
					req.task_priority_in <= on_bus.task_priority_in;
					req.delay_ticks      <= on_bus.delay_ticks;
					req.now_ticks        <= on_bus.now_ticks;
					req.stack_ptr        <= on_bus.stack_ptr;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: check each collected result against the oldest prediction
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, switch_outcome_t want, switch_outcome_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected task %0d sp %h none %b, got task %0d sp %h none %b",
				$realtime, what, want.next_task, want.next_stack_ptr, want.none_ready,
				got.next_task, got.next_stack_ptr, got.none_ready);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (switch_outcomes.size() == 0) begin
					report_mismatch("result with nothing predicted", '0,
						{rsp.next_task, rsp.next_stack_ptr, rsp.none_ready});
				end else begin
					oldest = switch_outcomes.pop_front();
					if (rsp.next_task !== oldest.next_task ||
							rsp.next_stack_ptr !== oldest.next_stack_ptr ||
							rsp.none_ready !== oldest.none_ready)
						report_mismatch("switch result mismatch", oldest,
							{rsp.next_task, rsp.next_stack_ptr, rsp.none_ready});
				end
			end
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				rsp.ready <= 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				sink_gap = $urandom_range(0, 17);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, counted down on its own
	always @(posedge clk)
		if (hold_left != 0)
			hold_left <= hold_left - 1;

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic add_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] idx,
			logic [PRIO_W-1:0] prio, logic [WORD_W-1:0] delay,
			logic [WORD_W-1:0] now, logic [WORD_W-1:0] sp);
		task_requests.push_back({op, idx, prio, delay, now, sp});
	endtask

	// Mostly well-formed traffic on a running tick count; a few requests carry
	// fully random times. Slot 0 is always created first, so a delay never
	// lands on a slot whose priority was never written.
	function automatic task_request_t random_request();
		task_request_t r;
		int unsigned pick;
		r.task_index       = TASK_W'($urandom);
		r.task_priority_in = ($urandom_range(0, 2) == 0) ? PRIO_W'($urandom)
		                                                 : PRIO_W'($urandom_range(0, 3));
		r.delay_ticks      = $urandom;
		r.now_ticks        = $urandom;
		r.stack_ptr        = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.op = OP_IGNORED;
		else if (pick < 25)
			r.op = OP_CREATE;
		else if (pick < 55)
			r.op = OP_DELAY;
		else
			r.op = OP_SWITCH;
		if ($urandom_range(0, 99) >= 6) begin
			tick += $urandom_range(0, 12);
			r.now_ticks   = tick;
			r.delay_ticks = ($urandom_range(0, 9) == 0) ? WORD_W'($urandom)
			                                            : WORD_W'($urandom_range(0, 80));
		end
		return r;
	endfunction

	task automatic add_random(int unsigned count);
		repeat (count)
			task_requests.push_back(random_request());
	endtask

	// Hold the sender until everything offered has been taken and answered
	task automatic drain_requests();
		while (task_requests.size() != 0 || req.valid || switch_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		req.valid            = 1'b0;
		req.op               = OP_CREATE;
		req.task_index       = '0;
		req.task_priority_in = '0;
		req.delay_ticks      = '0;
		req.now_ticks        = '0;
		req.stack_ptr        = '0;
		rsp.ready            = 1'b0;
		arst_n               = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part, light idling on both sides
		src_idle_pct  = 15;
		sink_idle_pct = 15;
		// switch before any create: nothing ready, slot 0 kept with the saved pointer
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd0, 32'hA5A5_0001);
		add_request(OP_CREATE, 3'd0, 8'd0, 32'd0, 32'd0, 32'h0000_0000);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		// two top priorities tie: the first after the running slot wins
		add_request(OP_CREATE, 3'd7, 8'd255, 32'd0, 32'd0, 32'hFFFF_FFFF);
		add_request(OP_CREATE, 3'd3, 8'd255, 32'd0, 32'd0, 32'h1234_5678);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd0, 32'h0000_0100);
		// wake time wraps past the top of the tick range
		add_request(OP_DELAY, 3'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd0, 32'h0000_0200);
		add_request(OP_DELAY, 3'd0, 8'd0, 32'd10, 32'd0, 32'd0);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd5, 32'h0000_0300);
		// every created slot blocked and not yet due
		add_request(OP_DELAY, 3'd0, 8'd0, 32'd0, 32'd5, 32'd0);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd4, 32'h0000_0400);
		// wake time equal to now counts as due
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd5, 32'h0000_0500);
		// largest tick wakes everything blocked
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_0600);
		// undefined op is swallowed without a result
		add_request(OP_IGNORED, 3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(OP_CREATE, 3'd1, 8'd1, 32'd0, 32'd0, 32'h1111_1111);
		add_request(OP_CREATE, 3'd2, 8'd128, 32'd0, 32'd0, 32'h2222_2222);
		add_request(OP_CREATE, 3'd4, 8'd254, 32'd0, 32'd0, 32'h4444_4444);
		add_request(OP_CREATE, 3'd5, 8'd127, 32'd0, 32'd0, 32'h5555_5555);
		add_request(OP_CREATE, 3'd6, 8'd64, 32'd0, 32'd0, 32'h6666_6666);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd6, 32'h8000_0000);
		add_request(OP_SWITCH, 3'd0, 8'd0, 32'd0, 32'd7, 32'h7FFF_FFFF);
		drain_requests();

		// Random traffic with bursty idling
		tick = 32'd100;
		src_idle_pct  = 20;
		sink_idle_pct = 20;
		add_random(650);
		drain_requests();

		// Back the scheduler up: hold the receiver, keep the sender busy
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_left     = 400;
		add_random(150);
		drain_requests();

		// Run the tick count through its wrap point
		tick = 32'hFFFF_F800;
		src_idle_pct  = 20;
		sink_idle_pct = 20;
		add_random(400);
		drain_requests();

		src_idle_pct  = 0;
		sink_idle_pct = 30;
		add_random(200);
		drain_requests();

		src_idle_pct  = 30;
		sink_idle_pct = 0;
		add_random(200);
		drain_requests();

		// Last stretch flat out
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		add_random(300);
		drain_requests();

		repeat (4 * NUM_TASKS) @(posedge clk);
		if (mismatches == 0 && switch_outcomes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
